[hdl/frns_pkg.sv]
// ----------------------------------------------------------------------------
// frns_pkg
// Shared types and constants for the fixed-radius neighbor select block.
// ----------------------------------------------------------------------------
package frns_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  // coordinate and threshold widths
  localparam int LON_W    = 29;
  localparam int LAT_W    = 28;
  localparam int ENTRY_W  = LON_W + LAT_W;
  localparam int RADIUS_W = 60;
  localparam int SQLON_W  = 2 * LON_W;
  localparam int SQLAT_W  = 2 * LAT_W;
  localparam int SUM_W    = SQLON_W + 1;

  // function codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  // one result beat
  typedef struct packed {
    logic selected;
    logic status;
  } res_t;

endpackage

[hdl/frns_ram.sv]
// ----------------------------------------------------------------------------
// frns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/fixed_radius_neighbor_select.sv]
// ----------------------------------------------------------------------------
// fixed_radius_neighbor_select
// Reference point table with clear, append and radius query.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  in        in   in_valid / in_stall   in_func, in_lon, in_lat
//  out       out  out_valid / out_stall out_selected, out_status
//  cfg       in   cfg_valid / cfg_ready cfg_radius_sq
//
//  Clear, append, unused codes and a query of an empty table finish without a scan.
//  A query reads one table entry a cycle through the single RAM read port:
//  the scan ends early when a match is found, else after the last entry.
//  Reset clears the count and the radius; table contents stay undefined,
//  no clearing pass. A stalled result is held in the output register while
//  the next item is taken; that item waits for the register to free up.
// ----------------------------------------------------------------------------
module fixed_radius_neighbor_select
  import frns_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic signed [LON_W-1:0] in_lon,
  input  logic signed [LAT_W-1:0] in_lat,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_selected,
  output logic                    out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [RADIUS_W-1:0]     cfg_radius_sq
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [3:0]          vld_r, vld_nxt;
  logic [RADIUS_W-1:0] radius_r;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_res_r, out_res_nxt;
  res_t                pend_r, pend_nxt;
  logic [LON_W-1:0]    q_lon_r;
  logic [LAT_W-1:0]    q_lat_r;
  logic [LON_W-1:0]    abs_lon_r;
  logic [LAT_W-1:0]    abs_lat_r;
  logic [SQLON_W-1:0]  sq_lon_r;
  logic [SQLAT_W-1:0]  sq_lat_r;
  logic [SUM_W-1:0]    sum_r;

  logic                in_acc, out_free, issue, match, scan_done;
  logic                fin;
  res_t                fin_res;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic signed [LON_W:0] d_lon;
  logic signed [LAT_W:0] d_lat;
  logic [LON_W:0]      mag_lon;
  logic [LAT_W:0]      mag_lat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid    = out_valid_r;
  assign out_selected = out_res_r.selected;
  assign out_status   = out_res_r.status;

  // append writes at the current fill level
  assign ram_we = in_acc && (in_func == FUNC_APPEND) &&
                  (count_r < CNT_W'(TABLE_DEPTH));

  frns_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata ({in_lat, in_lon}),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // distance datapath: diff/abs, square, sum, compare
  always_comb begin
    d_lon   = $signed({q_lon_r[LON_W-1], q_lon_r}) -
              $signed({ram_rdata[LON_W-1], ram_rdata[LON_W-1:0]});
    d_lat   = $signed({q_lat_r[LAT_W-1], q_lat_r}) -
              $signed({ram_rdata[ENTRY_W-1], ram_rdata[ENTRY_W-1:LON_W]});
    mag_lon = d_lon[LON_W] ? (LON_W+1)'(0) - d_lon : d_lon;
    mag_lat = d_lat[LAT_W] ? (LAT_W+1)'(0) - d_lat : d_lat;
  end

  always_ff @(posedge clk) begin
    abs_lon_r <= mag_lon[LON_W-1:0];
    abs_lat_r <= mag_lat[LAT_W-1:0];
    sq_lon_r  <= abs_lon_r * abs_lon_r;
    sq_lat_r  <= abs_lat_r * abs_lat_r;
    sum_r     <= {1'b0, sq_lon_r} + {{(SUM_W - SQLAT_W){1'b0}}, sq_lat_r};
  end

  assign match     = vld_r[3] && ({{(RADIUS_W - SUM_W){1'b0}}, sum_r} <= radius_r);
  assign issue     = (state_r == ST_SCAN) && (rd_idx_r < count_r) && !match;
  assign scan_done = (state_r == ST_SCAN) && (match ||
                     ((rd_idx_r == count_r) && (vld_r == 4'd0)));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    vld_nxt       = {vld_r[2:0], issue};
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_res_nxt   = out_res_r;
    fin           = 1'b0;
    fin_res       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_CLEAR: begin
              count_nxt = '0;
              fin       = 1'b1;
            end
            FUNC_APPEND: begin
              fin = 1'b1;
              if (ram_we) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                fin_res.status = 1'b1;
              end
            end
            FUNC_QUERY: begin
              if (count_r == '0) begin
                fin = 1'b1;
              end else begin
                rd_idx_nxt = '0;
                state_nxt  = ST_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (scan_done) begin
          fin              = 1'b1;
          fin_res.selected = match;
          vld_nxt          = '0;
        end
      end
      ST_PUSH: begin
        fin     = 1'b1;
        fin_res = pend_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand the result to the output register or park it
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = fin_res;
        state_nxt     = ST_IDLE;
      end else begin
        pend_nxt  = fin_res;
        state_nxt = ST_PUSH;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      vld_r       <= '0;
      radius_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        radius_r <= cfg_radius_sq;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    pend_r    <= pend_nxt;
    if (in_acc) begin
      q_lon_r <= in_lon;
      q_lat_r <= in_lat;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ram_we)
    else $error("table write during a scan");

  a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> (vld_r == 4'd0))
    else $error("distance pipeline busy outside a scan");

  a_push_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |-> out_valid_r)
    else $error("parked result while output register empty");

  a_res_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.selected && out_res_r.status))
    else $error("selected and status both set");

endmodule
